FILE: rtl/gspc_pkg.sv
// Shared types, constants and curve tables for the gas sensor ppm converter.
// No dependencies; every other file of the block but the checker imports this package.
package gspc_pkg;

    localparam int SMP_FIELD_W = 12;
    localparam int SUM_W       = 20;
    localparam int CNT_W       = 8;
    localparam int DIV_NUM_W   = 40;
    localparam int DIV_DEN_W   = 21;
    localparam int LOG_W       = 21;

    // Register indexes on the configuration port
    localparam logic [2:0] REG_REF_MV  = 3'd0;
    localparam logic [2:0] REG_FULL_SC = 3'd1;
    localparam logic [2:0] REG_VCC_MV  = 3'd2;
    localparam logic [2:0] REG_LOAD_RL = 3'd3;
    localparam logic [2:0] REG_RANGE   = 3'd4;
    localparam logic [2:0] REG_FACTOR  = 3'd5;

    localparam logic [12:0] RST_REF_MV  = 13'd3300;
    localparam logic [11:0] RST_FULL_SC = 12'd4095;
    localparam logic [12:0] RST_VCC_MV  = 13'd5000;
    localparam logic [15:0] RST_LOAD_RL = 16'd2560;
    localparam logic [12:0] RST_RANGE   = 13'd3300;
    localparam logic [15:0] RST_FACTOR  = 16'd2516;

    localparam logic [15:0] FACTOR_MIN     = 16'd25;
    localparam logic [15:0] FACTOR_DEFAULT = 16'd2516;
    localparam logic [12:0] RANGE_MIN      = 13'd100;
    localparam logic [20:0] V_SAT          = 21'h1FFFFF;
    localparam logic [16:0] LEVEL_ONE      = 17'd65536;
    localparam logic [19:0] PPM_X10_MAX    = 20'd1000000;
    localparam logic signed [41:0] CURVE_B = 42'sd718429;

    localparam logic REQ_MEASURE = 1'b0;
    localparam logic REQ_CALIB   = 1'b1;

    typedef struct packed {
        logic [12:0] ref_mv;
        logic [11:0] full_sc;
        logic [12:0] vcc_mv;
        logic [15:0] load_rl;
        logic [12:0] range_mv;
        logic [15:0] factor;
    } t_cfg;

    typedef struct packed {
        logic              req_type;
        logic [1:0]        gas_sel;
        logic [SUM_W-1:0]  sum;
        logic [CNT_W-1:0]  cnt;
    } t_job;

    typedef struct packed {
        logic [11:0] avg_adc;
        logic [12:0] voltage_mv;
        logic [16:0] level_q16;
        logic [19:0] ppm_x10;
        logic        ppm_valid;
        logic        calib_ok;
    } t_result;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic                 done;
        logic [DIV_NUM_W-1:0] quo;
    } t_div_rsp;

    typedef struct packed {
        logic        start;
        logic [31:0] val;
    } t_log_req;

    typedef struct packed {
        logic             done;
        logic [LOG_W-1:0] res;
    } t_log_rsp;

    // y*log2(10) per gas, Q16
    function automatic logic [17:0] curve_a(input logic [1:0] gas);
        logic [17:0] a;
        case (gas)
            2'd0:    a = 18'd45718;
            2'd1:    a = 18'd156748;
            2'd2:    a = 18'd115384;
            2'd3:    a = 18'd202466;
            default: a = 18'd45718;
        endcase
        return a;
    endfunction

    // Magnitude of the slope per gas, Q16; every slope is negative
    function automatic logic [16:0] curve_s_mag(input logic [1:0] gas);
        logic [16:0] s;
        case (gas)
            2'd0:    s = 17'd30802;
            2'd1:    s = 17'd22282;
            2'd2:    s = 17'd28836;
            2'd3:    s = 17'd94372;
            default: s = 17'd30802;
        endcase
        return s;
    endfunction

endpackage

FILE: rtl/gspc_div.sv
// Restoring divider, one quotient bit per cycle, shared by the back end.
// Depends on gspc_pkg for the request and response types.
module gspc_div import gspc_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic                 r_busy;
    logic                 r_done;
    logic [5:0]           r_cnt;
    logic [DIV_DEN_W-1:0] r_rem;
    logic [DIV_DEN_W-1:0] r_den;
    logic [DIV_NUM_W-1:0] r_quo;

    logic [DIV_DEN_W:0] trial;
    logic [DIV_DEN_W:0] diff;
    logic               ge;

    assign trial = {r_rem, r_quo[DIV_NUM_W-1]};
    assign ge    = trial >= {1'b0, r_den};
    assign diff  = trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'(DIV_NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.num;
            r_den <= i_req.den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIV_NUM_W-2:0], ge};
            r_rem <= ge ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

endmodule

FILE: rtl/gspc_log2.sv
// Iterative log2 in Q16: normalize, then sixteen square-and-compare steps.
// Depends on gspc_pkg for the request and response types.
module gspc_log2 import gspc_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_log_req i_req,
    output t_log_rsp o_rsp
);

    localparam logic [1:0] LG_IDLE = 2'd0;
    localparam logic [1:0] LG_NORM = 2'd1;
    localparam logic [1:0] LG_MUL  = 2'd2;
    localparam logic [1:0] LG_CHK  = 2'd3;

    logic [1:0]  r_state;
    logic        r_done;
    logic [31:0] r_x;
    logic [4:0]  r_p;
    logic [30:0] r_m;
    logic [61:0] r_sq;
    logic [15:0] r_frac;
    logic [3:0]  r_idx;

    logic [31:0] sq_top;

    assign sq_top = r_sq[61:30];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= LG_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                LG_IDLE: begin
                    if (i_req.start) begin
                        r_state <= LG_NORM;
                    end
                end
                LG_NORM: begin
                    if (r_x[31]) begin
                        r_state <= LG_MUL;
                    end
                end
                LG_MUL: begin
                    r_state <= LG_CHK;
                end
                LG_CHK: begin
                    if (r_idx == 4'd0) begin
                        r_state <= LG_IDLE;
                        r_done  <= 1'b1;
                    end else begin
                        r_state <= LG_MUL;
                    end
                end
                default: r_state <= LG_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            LG_IDLE: begin
                r_x <= i_req.val;
                r_p <= 5'd31;
            end
            LG_NORM: begin
                // shift by a byte while the top byte is empty, else by one bit
                if (r_x[31:24] == 8'd0) begin
                    r_x <= {r_x[23:0], 8'd0};
                    r_p <= r_p - 5'd8;
                end else if (!r_x[31]) begin
                    r_x <= {r_x[30:0], 1'b0};
                    r_p <= r_p - 5'd1;
                end else begin
                    r_m    <= r_x[31:1];
                    r_idx  <= 4'd15;
                    r_frac <= '0;
                end
            end
            LG_MUL: begin
                r_sq <= r_m * r_m;
            end
            LG_CHK: begin
                if (sq_top[31]) begin
                    r_m           <= sq_top[31:1];
                    r_frac[r_idx] <= 1'b1;
                end else begin
                    r_m <= sq_top[30:0];
                end
                r_idx <= r_idx - 4'd1;
            end
            default: ;
        endcase
    end

    assign o_rsp.done = r_done;
    assign o_rsp.res  = {r_p, r_frac};

endmodule

FILE: rtl/gspc_front.sv
// Front end: sums accepted samples and classifies the read at its last beat.
// Depends on gspc_pkg; pushes one job per read into the job queue.
module gspc_front import gspc_pkg::*; #(
    parameter int ADC_BITS    = 12,
    parameter int MAX_SAMPLES = 255
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [SMP_FIELD_W-1:0] i_sample,
    input  logic                   i_last,
    input  logic                   i_req_type,
    input  logic [1:0]             i_gas_sel,
    input  logic                   i_q_full,
    output logic                   o_push,
    output t_job                   o_job
);

    localparam int SMP_W = (ADC_BITS < SMP_FIELD_W) ? ADC_BITS : SMP_FIELD_W;
    localparam logic [SMP_FIELD_W-1:0] SMP_MASK = SMP_FIELD_W'((64'd1 << SMP_W) - 64'd1);

    logic [SUM_W-1:0] r_sum;
    logic [CNT_W-1:0] r_cnt;
    logic [SUM_W-1:0] n_sum;
    logic [CNT_W-1:0] n_cnt;
    logic             beat;

    assign o_ready = !i_q_full;
    assign beat    = i_valid && o_ready;

    always_comb begin
        n_sum = r_sum;
        n_cnt = r_cnt;
        // drop samples once the read holds the maximum count
        if (r_cnt < CNT_W'(MAX_SAMPLES)) begin
            n_sum = r_sum + SUM_W'(i_sample & SMP_MASK);
            n_cnt = r_cnt + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
            r_cnt <= '0;
        end else if (beat) begin
            if (i_last) begin
                r_sum <= '0;
                r_cnt <= '0;
            end else begin
                r_sum <= n_sum;
                r_cnt <= n_cnt;
            end
        end
    end

    assign o_push           = beat && i_last;
    assign o_job.req_type   = i_req_type;
    assign o_job.gas_sel    = i_gas_sel;
    assign o_job.sum        = n_sum;
    assign o_job.cnt        = n_cnt;

endmodule

FILE: rtl/gspc_queue.sv
// Two-entry job queue between the front end and the back end.
// Depends on gspc_pkg for the job type.
module gspc_queue import gspc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    output logic o_valid,
    input  logic i_pop,
    output t_job o_job
);

    t_job       r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= !r_wptr;
            end
            if (i_pop) begin
                r_rptr <= !r_rptr;
            end
            r_count <= r_count + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    assign o_full  = r_count == 2'd2;
    assign o_valid = r_count != 2'd0;
    assign o_job   = r_mem[r_rptr];

endmodule

FILE: rtl/gspc_back.sv
// Back end: turns one job into a result through a sequencer that drives
// the shared divider and log2 unit. Depends on gspc_pkg, gspc_div, gspc_log2.
module gspc_back import gspc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_job_valid,
    input  t_job    i_job,
    output logic    o_job_pop,
    output logic    o_res_valid,
    input  logic    i_res_ready,
    output t_result o_res
);

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_AVG    = 5'd1;
    localparam logic [4:0] S_VSTART = 5'd2;
    localparam logic [4:0] S_V      = 5'd3;
    localparam logic [4:0] S_LVL    = 5'd4;
    localparam logic [4:0] S_RSTART = 5'd5;
    localparam logic [4:0] S_RS     = 5'd6;
    localparam logic [4:0] S_DECIDE = 5'd7;
    localparam logic [4:0] S_R0     = 5'd8;
    localparam logic [4:0] S_LRS    = 5'd9;
    localparam logic [4:0] S_LR0    = 5'd10;
    localparam logic [4:0] S_E      = 5'd11;
    localparam logic [4:0] S_SRCH   = 5'd12;
    localparam logic [4:0] S_SLOG   = 5'd13;
    localparam logic [4:0] S_PFIN   = 5'd14;
    localparam logic [4:0] S_OUT    = 5'd15;

    logic [4:0]        r_state;
    t_job              r_job;
    logic [11:0]       r_avg;
    logic [39:0]       r_prod;
    logic [20:0]       r_v;
    logic [16:0]       r_level;
    logic [31:0]       r_rs;
    logic [31:0]       r_r0;
    logic              r_cav;
    logic              r_cok;
    logic [LOG_W-1:0]  r_lrs;
    logic              r_nneg;
    logic signed [41:0] r_e;
    logic [19:0]       r_p;
    logic [4:0]        r_bit;
    logic [19:0]       r_ppm;
    logic              r_pvalid;
    logic              r_ov;
    t_result           r_out;
    t_div_req          r_dreq;
    t_log_req          r_lreq;

    t_div_rsp          drsp;
    t_log_rsp          lrsp;

    logic [11:0]       fs_eff;
    logic [12:0]       fr_eff;
    logic [15:0]       fac_eff;
    logic [20:0]       vcc_q8;
    logic [DIV_NUM_W-1:0] quo;
    logic [31:0]       quo_sat32;
    logic signed [22:0] ldiff;
    logic [21:0]       ldiff_mag;
    logic signed [41:0] qs;
    logic [19:0]       cand;
    logic              slot_free;

    gspc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_dreq),
        .o_rsp   (drsp)
    );

    gspc_log2 u_log (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_lreq),
        .o_rsp   (lrsp)
    );

    assign fs_eff    = (i_cfg.full_sc == 12'd0) ? 12'd1 : i_cfg.full_sc;
    assign fr_eff    = (i_cfg.range_mv < RANGE_MIN) ? RANGE_MIN : i_cfg.range_mv;
    assign fac_eff   = (i_cfg.factor <= FACTOR_MIN) ? FACTOR_DEFAULT : i_cfg.factor;
    assign vcc_q8    = {i_cfg.vcc_mv, 8'd0};
    assign quo       = drsp.quo;
    assign quo_sat32 = (quo[39:32] != 8'd0) ? 32'hFFFF_FFFF : quo[31:0];
    assign ldiff     = $signed({2'b00, r_lrs}) - $signed({2'b00, lrsp.res})
                     - $signed({5'd0, curve_a(r_job.gas_sel)});
    assign ldiff_mag = ldiff[22] ? 22'(-ldiff) : ldiff[21:0];
    assign qs        = $signed({2'b00, quo});
    assign cand      = r_p | (20'd1 << r_bit);
    assign slot_free = !r_ov || i_res_ready;
    assign o_job_pop = (r_state == S_IDLE) && i_job_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cav   <= 1'b0;
            r_r0    <= '0;
            r_ov    <= 1'b0;
            r_dreq  <= '0;
            r_lreq  <= '0;
        end else begin
            r_dreq.start <= 1'b0;
            r_lreq.start <= 1'b0;
            if (r_ov && i_res_ready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_job        <= i_job;
                        r_cok        <= 1'b0;
                        r_ppm        <= '0;
                        r_pvalid     <= 1'b0;
                        r_dreq.start <= 1'b1;
                        r_dreq.num   <= DIV_NUM_W'(i_job.sum);
                        r_dreq.den   <= DIV_DEN_W'(i_job.cnt);
                        r_state      <= S_AVG;
                    end
                end
                S_AVG: begin
                    if (drsp.done) begin
                        r_avg   <= quo[11:0];
                        r_prod  <= 40'(25'(quo[11:0]) * 25'(i_cfg.ref_mv));
                        r_state <= S_VSTART;
                    end
                end
                S_VSTART: begin
                    r_dreq.start <= 1'b1;
                    r_dreq.num   <= {r_prod[31:0], 8'd0};
                    r_dreq.den   <= DIV_DEN_W'(fs_eff);
                    r_state      <= S_V;
                end
                S_V: begin
                    if (drsp.done) begin
                        r_v          <= (quo[39:21] != 19'd0) ? V_SAT : quo[20:0];
                        r_dreq.start <= 1'b1;
                        r_dreq.num   <= (quo[39:21] != 19'd0) ? DIV_NUM_W'({V_SAT, 8'd0})
                                                              : DIV_NUM_W'({quo[20:0], 8'd0});
                        r_dreq.den   <= DIV_DEN_W'(fr_eff);
                        r_state      <= S_LVL;
                    end
                end
                S_LVL: begin
                    if (drsp.done) begin
                        r_level <= (quo > 40'(LEVEL_ONE)) ? LEVEL_ONE : quo[16:0];
                        // zero volts or at the rail: no resistance
                        if (r_v == 21'd0 || r_v >= vcc_q8) begin
                            r_rs    <= '0;
                            r_state <= S_DECIDE;
                        end else begin
                            r_prod  <= 40'(37'(i_cfg.load_rl) * 37'(vcc_q8 - r_v));
                            r_state <= S_RSTART;
                        end
                    end
                end
                S_RSTART: begin
                    r_dreq.start <= 1'b1;
                    r_dreq.num   <= r_prod;
                    r_dreq.den   <= r_v;
                    r_state      <= S_RS;
                end
                S_RS: begin
                    if (drsp.done) begin
                        r_rs    <= quo_sat32;
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    if (r_job.req_type == REQ_CALIB) begin
                        if (r_rs == 32'd0) begin
                            r_r0    <= '0;
                            r_cav   <= 1'b0;
                            r_state <= S_OUT;
                        end else begin
                            r_dreq.start <= 1'b1;
                            r_dreq.num   <= {r_rs, 8'd0};
                            r_dreq.den   <= DIV_DEN_W'(fac_eff);
                            r_state      <= S_R0;
                        end
                    end else if (r_cav && r_r0 != 32'd0 && r_rs != 32'd0) begin
                        r_lreq.start <= 1'b1;
                        r_lreq.val   <= r_rs;
                        r_state      <= S_LRS;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_R0: begin
                    if (drsp.done) begin
                        r_r0    <= quo_sat32;
                        r_cav   <= quo_sat32 != 32'd0;
                        r_cok   <= quo_sat32 != 32'd0;
                        r_state <= S_OUT;
                    end
                end
                S_LRS: begin
                    if (lrsp.done) begin
                        r_lrs        <= lrsp.res;
                        r_lreq.start <= 1'b1;
                        r_lreq.val   <= r_r0;
                        r_state      <= S_LR0;
                    end
                end
                S_LR0: begin
                    if (lrsp.done) begin
                        r_nneg       <= ldiff[22];
                        r_dreq.start <= 1'b1;
                        r_dreq.num   <= DIV_NUM_W'({ldiff_mag, 16'd0});
                        r_dreq.den   <= DIV_DEN_W'(curve_s_mag(r_job.gas_sel));
                        r_state      <= S_E;
                    end
                end
                S_E: begin
                    if (drsp.done) begin
                        // slope is negative: the quotient takes the opposite sign
                        r_e     <= r_nneg ? (CURVE_B + qs) : (CURVE_B - qs);
                        r_p     <= '0;
                        r_bit   <= 5'd19;
                        r_state <= S_SRCH;
                    end
                end
                S_SRCH: begin
                    if (cand > PPM_X10_MAX) begin
                        if (r_bit == 5'd0) begin
                            r_state <= S_PFIN;
                        end else begin
                            r_bit <= r_bit - 5'd1;
                        end
                    end else begin
                        r_lreq.start <= 1'b1;
                        r_lreq.val   <= 32'(cand);
                        r_state      <= S_SLOG;
                    end
                end
                S_SLOG: begin
                    if (lrsp.done) begin
                        if ($signed({21'd0, lrsp.res}) <= r_e) begin
                            r_p <= cand;
                        end
                        if (r_bit == 5'd0) begin
                            r_state <= S_PFIN;
                        end else begin
                            r_bit   <= r_bit - 5'd1;
                            r_state <= S_SRCH;
                        end
                    end
                end
                S_PFIN: begin
                    r_ppm    <= (r_p == 20'd0) ? 20'd1 : r_p;
                    r_pvalid <= 1'b1;
                    r_state  <= S_OUT;
                end
                S_OUT: begin
                    if (slot_free) begin
                        r_ov    <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && slot_free) begin
            r_out.avg_adc    <= r_avg;
            r_out.voltage_mv <= r_v[20:8];
            r_out.level_q16  <= r_level;
            r_out.ppm_x10    <= r_ppm;
            r_out.ppm_valid  <= r_pvalid;
            r_out.calib_ok   <= r_cok;
        end
    end

    assign o_res_valid = r_ov;
    assign o_res       = r_out;

endmodule

FILE: rtl/gas_sensor_ppm_converter_core.sv
// Gas sensor ppm converter. Samples stream in at one per cycle while the
// job queue is not full and are summed until the beat with tlast; that read
// becomes one job in a two-entry queue, and one result beat leaves per read.
// The back end works one job at a time with a shared divider and a log2
// unit. A measure read with a calibrated sensor runs a ppm bit search of up
// to twenty log2 evaluations; measure reads without calibration skip it, and
// reads at zero volts or at the rail skip the resistance division. Depends
// on gspc_pkg.
module gas_sensor_ppm_converter_core import gspc_pkg::*; #(
    parameter int ADC_BITS    = 12,
    parameter int MAX_SAMPLES = 255
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,  // [11:0] adc_sample
    input  logic [2:0]  i_s_axis_tuser,  // [0] req_type, [2:1] gas_sel
    input  logic        i_s_axis_tlast,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [63:0] o_m_axis_tdata,  // avg_adc, voltage_mv, level_q16, ppm_x10
    output logic [1:0]  o_m_axis_tuser,  // [0] ppm_valid, [1] calib_ok
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [4:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output logic        o_pready
);

    logic [12:0] r_ref_mv;
    logic [11:0] r_full_sc;
    logic [12:0] r_vcc_mv;
    logic [15:0] r_load_rl;
    logic [12:0] r_range_mv;
    logic [15:0] r_factor;

    logic    wr_en;
    t_cfg    cfg;
    logic    q_full;
    logic    q_valid;
    logic    q_pop;
    logic    push;
    t_job    push_job;
    t_job    pop_job;
    t_result res;

    assign o_pready = 1'b1;
    assign wr_en    = i_psel && i_penable && i_pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_mv   <= RST_REF_MV;
            r_full_sc  <= RST_FULL_SC;
            r_vcc_mv   <= RST_VCC_MV;
            r_load_rl  <= RST_LOAD_RL;
            r_range_mv <= RST_RANGE;
            r_factor   <= RST_FACTOR;
        end else if (wr_en) begin
            case (i_paddr[4:2])
                REG_REF_MV:  r_ref_mv   <= i_pwdata[12:0];
                REG_FULL_SC: r_full_sc  <= i_pwdata[11:0];
                REG_VCC_MV:  r_vcc_mv   <= i_pwdata[12:0];
                REG_LOAD_RL: r_load_rl  <= i_pwdata[15:0];
                REG_RANGE:   r_range_mv <= i_pwdata[12:0];
                REG_FACTOR:  r_factor   <= i_pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (i_paddr[4:2])
            REG_REF_MV:  o_prdata = 32'(r_ref_mv);
            REG_FULL_SC: o_prdata = 32'(r_full_sc);
            REG_VCC_MV:  o_prdata = 32'(r_vcc_mv);
            REG_LOAD_RL: o_prdata = 32'(r_load_rl);
            REG_RANGE:   o_prdata = 32'(r_range_mv);
            REG_FACTOR:  o_prdata = 32'(r_factor);
            default:     o_prdata = 32'd0;
        endcase
    end

    assign cfg.ref_mv   = r_ref_mv;
    assign cfg.full_sc  = r_full_sc;
    assign cfg.vcc_mv   = r_vcc_mv;
    assign cfg.load_rl  = r_load_rl;
    assign cfg.range_mv = r_range_mv;
    assign cfg.factor   = r_factor;

    gspc_front #(
        .ADC_BITS    (ADC_BITS),
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_s_axis_tvalid),
        .o_ready    (o_s_axis_tready),
        .i_sample   (i_s_axis_tdata[11:0]),
        .i_last     (i_s_axis_tlast),
        .i_req_type (i_s_axis_tuser[0]),
        .i_gas_sel  (i_s_axis_tuser[2:1]),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_job      (push_job)
    );

    gspc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_job   (pop_job)
    );

    gspc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_job_valid (q_valid),
        .i_job       (pop_job),
        .o_job_pop   (q_pop),
        .o_res_valid (o_m_axis_tvalid),
        .i_res_ready (i_m_axis_tready),
        .o_res       (res)
    );

    assign o_m_axis_tdata = {2'b00, res.ppm_x10, res.level_q16, res.voltage_mv, res.avg_adc};
    assign o_m_axis_tuser = {res.calib_ok, res.ppm_valid};

endmodule

FILE: rtl/gspc_checker.sv
// Port-level checks on the result stream of the converter core.
// Bound to gas_sensor_ppm_converter_core; no package dependency.
module gspc_assert_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [63:0] o_m_axis_tdata,
    input logic [1:0]  o_m_axis_tuser
);

    // hold a stalled result beat
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("result beat changed while stalled");

    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !(o_m_axis_tuser[0] && o_m_axis_tuser[1]))
        else $error("ppm_valid and calib_ok both set");

    a_no_ppm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser[0] |-> o_m_axis_tdata[61:42] == 20'd0)
        else $error("ppm present without ppm_valid");

    a_ppm_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[0] |->
            o_m_axis_tdata[61:42] != 20'd0 && o_m_axis_tdata[61:42] <= 20'd1000000)
        else $error("ppm out of range");

    a_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[41:25] <= 17'd65536)
        else $error("level above one");

endmodule

bind gas_sensor_ppm_converter_core gspc_assert_checker u_gspc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);
